// ===== hdl/greedy_min_cost_assignment_unit_assert.svh =====
// Assertion macros for the greedy minimum-cost assignment unit.
// Expect clk and rst_n in scope where they are expanded.
`ifndef GREEDY_MIN_COST_ASSIGNMENT_UNIT_ASSERT_SVH
`define GREEDY_MIN_COST_ASSIGNMENT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define GMCA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gmca: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define GMCA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gmca: next-cycle check failed");

`endif

// ===== hdl/gmca_pkg.sv =====
// Shared widths for the greedy minimum-cost assignment unit.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package gmca_pkg;

    // Width of one signed matrix cost
    localparam int unsigned COST_W = 16;
    // Width of the worker and job index fields of a result item
    localparam int unsigned IDX_W  = 2;

    typedef logic signed [COST_W-1:0] cost_t;
    typedef logic        [IDX_W-1:0]  idx_t;

endpackage

// ===== hdl/gmca_cost_if.sv =====
// Input channel carrying one matrix cost per item.
// Depends on gmca_pkg for the payload type.
`timescale 1ns / 1ps

interface gmca_cost_if;
    import gmca_pkg::*;

    logic  valid;
    logic  ready;
    cost_t cost;

    modport source (output valid, output cost, input ready);
    modport sink   (input valid, input cost, output ready);
endinterface

// ===== hdl/gmca_pair_if.sv =====
// Output channel carrying one chosen worker/job pairing per item.
// Depends on gmca_pkg for the payload types.
`timescale 1ns / 1ps

interface gmca_pair_if;
    import gmca_pkg::*;

    logic  valid;
    logic  ready;
    idx_t  worker;
    idx_t  task_res;
    cost_t chosen_cost;
    logic  last_pair;

    modport source (output valid, output worker, output task_res,
                    output chosen_cost, output last_pair, input ready);
    modport sink   (input valid, input worker, input task_res,
                    input chosen_cost, input last_pair, output ready);
endinterface

// ===== hdl/gmca_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module gmca_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/greedy_min_cost_assignment_unit.sv =====
// Greedy minimum-cost assignment. Costs arrive one item per cycle while in
// LOAD, in row-major order (row = worker, column = job), and are written to
// a SIZE_N*SIZE_N entry RAM. After the last cost, SIZE_N rounds run; each
// round sweeps the whole RAM through its single read port, one entry per
// cycle, skipping used rows and columns, and then emits the smallest cost
// found (ties to the first entry in row-major order), waiting while the
// output is stalled. No costs are taken during the rounds; the final
// result of a matrix carries last_pair, and loading of the next matrix
// starts at once.
// Depends on gmca_pkg, the channel interfaces, gmca_ram and the assert macros.
`timescale 1ns / 1ps
`include "greedy_min_cost_assignment_unit_assert.svh"

module greedy_min_cost_assignment_unit
    import gmca_pkg::*;
#(
    parameter int unsigned SIZE_N = 4
) (
    input logic         clk,
    input logic         rst_n,
    gmca_cost_if.sink   cost_ch,
    gmca_pair_if.source pair_ch
);

    localparam int unsigned CELLS = SIZE_N * SIZE_N;
    localparam int unsigned AW    = $clog2(CELLS);
    localparam int unsigned RW    = $clog2(SIZE_N);
    // index width wide enough to hold both a row number and an output field
    localparam int unsigned XW    = (RW > IDX_W) ? RW : IDX_W;

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [RW-1:0] LAST_IDX  = RW'(SIZE_N - 1);

    typedef enum logic [1:0] {
        LOAD,
        SCAN,
        DRAIN,
        EMIT
    } state_t;

    // control
    state_t            state_reg,     state_next;
    logic [AW-1:0]     load_cnt_reg,  load_cnt_next;
    logic [AW-1:0]     scan_addr_reg, scan_addr_next;
    logic [RW-1:0]     scan_row_reg,  scan_row_next;
    logic [RW-1:0]     scan_col_reg,  scan_col_next;
    logic [RW-1:0]     round_reg,     round_next;
    logic [SIZE_N-1:0] rows_taken_reg, rows_taken_next;
    logic [SIZE_N-1:0] cols_taken_reg, cols_taken_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              found_reg,     found_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [RW-1:0]     pend_row_reg, pend_col_reg;
    cost_t             best_reg,     best_next;
    logic [RW-1:0]     best_row_reg, best_row_next;
    logic [RW-1:0]     best_col_reg, best_col_next;
    idx_t              worker_reg, task_reg;
    cost_t             chosen_reg;
    logic              last_reg;

    // RAM ports
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [COST_W-1:0] ram_rd_data;
    cost_t             rd_cost;

    logic              in_acc;
    logic              out_free;
    logic              emit_fire;
    logic              better;
    logic [XW-1:0]     row_ext, col_ext;

    gmca_ram #(
        .WIDTH (COST_W),
        .DEPTH (CELLS)
    ) u_cost_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (load_cnt_reg),
        .wr_data (cost_ch.cost),
        .rd_en   (ram_rd_en),
        .rd_addr (scan_addr_reg),
        .rd_data (ram_rd_data)
    );

    // handshakes
    assign cost_ch.ready = (state_reg == LOAD);
    assign in_acc        = cost_ch.valid && cost_ch.ready;
    assign out_free      = !out_valid_reg || pair_ch.ready;
    assign emit_fire     = (state_reg == EMIT) && out_free;
    assign ram_wr_en     = in_acc;
    assign ram_rd_en     = (state_reg == SCAN);
    assign rd_cost       = cost_t'(ram_rd_data);

    // candidate test on the entry returned by the RAM
    assign better = pend_valid_reg && !rows_taken_reg[pend_row_reg]
                    && !cols_taken_reg[pend_col_reg]
                    && (!found_reg || (rd_cost < best_reg));

    // index fields keep the low bits of the row and column
    assign row_ext = XW'(best_row_reg);
    assign col_ext = XW'(best_col_reg);

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        load_cnt_next   = load_cnt_reg;
        scan_addr_next  = scan_addr_reg;
        scan_row_next   = scan_row_reg;
        scan_col_next   = scan_col_reg;
        round_next      = round_reg;
        rows_taken_next = rows_taken_reg;
        cols_taken_next = cols_taken_reg;
        pend_valid_next = 1'b0;
        found_next      = found_reg;
        best_next       = best_reg;
        best_row_next   = best_row_reg;
        best_col_next   = best_col_reg;
        out_valid_next  = out_valid_reg && !pair_ch.ready;

        // running minimum over the swept entries
        if (better)
        begin
            found_next    = 1'b1;
            best_next     = rd_cost;
            best_row_next = pend_row_reg;
            best_col_next = pend_col_reg;
        end

        unique case (state_reg)
            LOAD:
            begin
                if (in_acc)
                begin
                    if (load_cnt_reg == LAST_CELL)
                    begin
                        load_cnt_next   = '0;
                        state_next      = SCAN;
                        scan_addr_next  = '0;
                        scan_row_next   = '0;
                        scan_col_next   = '0;
                        round_next      = '0;
                        rows_taken_next = '0;
                        cols_taken_next = '0;
                        found_next      = 1'b0;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + AW'(1);
                    end
                end
            end
            SCAN:
            begin
                pend_valid_next = 1'b1;
                scan_addr_next  = scan_addr_reg + AW'(1);
                if (scan_col_reg == LAST_IDX)
                begin
                    scan_col_next = '0;
                    scan_row_next = scan_row_reg + RW'(1);
                end
                else
                begin
                    scan_col_next = scan_col_reg + RW'(1);
                end
                if (scan_addr_reg == LAST_CELL)
                begin
                    state_next = DRAIN;
                end
            end
            DRAIN:
            begin
                // the last entry of the sweep is compared in this cycle
                state_next = EMIT;
            end
            EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    rows_taken_next = rows_taken_reg | (SIZE_N'(1) << best_row_reg);
                    cols_taken_next = cols_taken_reg | (SIZE_N'(1) << best_col_reg);
                    found_next      = 1'b0;
                    scan_addr_next  = '0;
                    scan_row_next   = '0;
                    scan_col_next   = '0;
                    if (round_reg == LAST_IDX)
                    begin
                        round_next = '0;
                        state_next = LOAD;
                    end
                    else
                    begin
                        round_next = round_reg + RW'(1);
                        state_next = SCAN;
                    end
                end
            end
            default:
            begin
                state_next = LOAD;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= LOAD;
            load_cnt_reg   <= '0;
            scan_addr_reg  <= '0;
            scan_row_reg   <= '0;
            scan_col_reg   <= '0;
            round_reg      <= '0;
            rows_taken_reg <= '0;
            cols_taken_reg <= '0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_cnt_reg   <= load_cnt_next;
            scan_addr_reg  <= scan_addr_next;
            scan_row_reg   <= scan_row_next;
            scan_col_reg   <= scan_col_next;
            round_reg      <= round_next;
            rows_taken_reg <= rows_taken_next;
            cols_taken_reg <= cols_taken_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers: read pipeline, running best, output item
    always_ff @(posedge clk)
    begin
        pend_row_reg <= scan_row_reg;
        pend_col_reg <= scan_col_reg;
        best_reg     <= best_next;
        best_row_reg <= best_row_next;
        best_col_reg <= best_col_next;
        if (emit_fire)
        begin
            worker_reg <= row_ext[IDX_W-1:0];
            task_reg   <= col_ext[IDX_W-1:0];
            chosen_reg <= best_reg;
            last_reg   <= (round_reg == LAST_IDX);
        end
    end

    assign pair_ch.valid       = out_valid_reg;
    assign pair_ch.worker      = worker_reg;
    assign pair_ch.task_res    = task_reg;
    assign pair_ch.chosen_cost = chosen_reg;
    assign pair_ch.last_pair   = last_reg;

    // checks
    `GMCA_ASSERT_NEXT(a_start_clean, in_acc && (load_cnt_reg == LAST_CELL),
        (state_reg == SCAN) && (rows_taken_reg == '0) && (cols_taken_reg == '0))
    `GMCA_ASSERT_NOW(a_pick_free, state_reg == EMIT,
        found_reg && !rows_taken_reg[best_row_reg] && !cols_taken_reg[best_col_reg])
    `GMCA_ASSERT_NOW(a_mask_count, state_reg == SCAN,
        ($countones(rows_taken_reg) == int'(round_reg))
        && ($countones(cols_taken_reg) == int'(round_reg)))
    `GMCA_ASSERT_NEXT(a_final_item, emit_fire && (round_reg == LAST_IDX),
        (state_reg == LOAD) && pair_ch.valid && pair_ch.last_pair)

endmodule
